>>> hdl/fmenc_pkg.sv
// ----------------------------------------------------------------------------
// fmenc_pkg
// Shared types, action codes and cell/crc helpers for the FM/MFM encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package fmenc_pkg;

    localparam int unsigned ACTION_W = 3;
    localparam int unsigned VALUE_W  = 16;
    localparam int unsigned CELLS_W  = 16;

    localparam logic [ACTION_W-1:0] ACT_DATA      = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_RAW       = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_CRC_EMIT  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_CRC_RESET = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CRC_LOAD  = 3'd4;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // result queue: two words from one item plus one still waiting
    localparam int unsigned QDEPTH = 3;

    typedef struct packed {
        logic [CELLS_W-1:0] cells;
        logic               last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    w0;
        result_t    w1;
    } push_t;

    // clock cell then data cell per bit, msb first; prev is the bit before b[7]
    function automatic logic [CELLS_W-1:0] encode_cells(input logic       dd,
                                                        input logic       prev,
                                                        input logic [7:0] b);
        logic [8:0]         d;
        logic [CELLS_W-1:0] c;
        d = {prev, b};
        for (int i = 0; i < 8; i++) begin
            c[2*i+1] = dd ? ~(d[i] | d[i+1]) : 1'b1;
            c[2*i]   = d[i];
        end
        return c;
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                             input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> hdl/fmenc_out_queue.sv
// ----------------------------------------------------------------------------
// fmenc_out_queue
// Three-entry result queue; takes up to two words a cycle, hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module fmenc_out_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire fmenc_pkg::push_t  push,
    output logic                   room,
    output logic                   head_valid,
    input  wire logic              head_ready,
    output fmenc_pkg::result_t     head
);

    fmenc_pkg::result_t q_reg  [fmenc_pkg::QDEPTH];
    fmenc_pkg::result_t q_next [fmenc_pkg::QDEPTH];
    logic [1:0]         count_reg;
    logic [1:0]         count_next;
    logic [1:0]         base;
    logic               pop;

    assign head_valid = (count_reg != 2'd0);
    assign head       = q_reg[0];
    assign pop        = head_valid && head_ready;
    // room for two words regardless of what the output side does
    assign room       = (count_reg <= 2'd1);

    always_comb
    begin
        q_next = q_reg;
        base   = count_reg;
        if (pop)
        begin
            q_next[0] = q_reg[1];
            q_next[1] = q_reg[2];
            base      = count_reg - 2'd1;
        end
        for (int i = 0; i < fmenc_pkg::QDEPTH; i++) begin
            if (push.count != 2'd0 && 2'(i) == base)
            begin
                q_next[i] = push.w0;
            end
            if (push.count == 2'd2 && 2'(i) == base + 2'd1)
            begin
                q_next[i] = push.w1;
            end
        end
        count_next = base + push.count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

endmodule

`default_nettype wire

>>> hdl/fm_mfm_byte_encoder_crc.sv
// ----------------------------------------------------------------------------
// fm_mfm_byte_encoder_crc
// Floppy write-side FM/MFM byte encoder with CRC-16-CCITT generation.
// ----------------------------------------------------------------------------
//  channel | signals                       | moves
//  cfg     | cfg_valid cfg_ready cfg_data  | double_density select
//  in      | in_valid in_ready action value| one action per transaction
//  out     | out_valid out_ready cells last| one 16-cell word per transaction
//
//  encoding and crc update are flat logic between the state registers and a
//  three-entry result queue.
//  sustained rate is one item per cycle while out_ready stays high; a crc emit
//  makes two words, so in_ready drops until the queue has drained the extra one.
//  in_ready depends only on queue fill, never combinationally on out_ready.
//  after reset: mfm selected, crc 0xffff, previous data bit 0, queue empty.
// ----------------------------------------------------------------------------
`default_nettype none

module fm_mfm_byte_encoder_crc (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  action,
    input  wire logic [15:0] value,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      cells,
    output logic             last
);

    logic               dd_reg;
    logic               prev_reg;
    logic               prev_next;
    logic [15:0]        crc_reg;
    logic [15:0]        crc_next;
    logic               accept;
    logic               room;
    logic               prev_mid;
    fmenc_pkg::push_t   push;
    fmenc_pkg::result_t head;

    assign cfg_ready = 1'b1;
    assign in_ready  = room;
    assign accept    = in_valid && in_ready;
    assign prev_mid  = dd_reg ? crc_reg[8] : prev_reg;

    always_comb
    begin
        push      = '0;
        crc_next  = crc_reg;
        prev_next = prev_reg;
        if (accept)
        begin
            case (action)
                fmenc_pkg::ACT_DATA:
                begin
                    push.count = 2'd1;
                    push.w0    = '{cells: fmenc_pkg::encode_cells(dd_reg, prev_reg,
                                                                  value[7:0]),
                                   last: 1'b1};
                    crc_next   = fmenc_pkg::crc_byte(crc_reg, value[7:0]);
                    prev_next  = dd_reg ? value[0] : prev_reg;
                end
                fmenc_pkg::ACT_RAW:
                begin
                    push.count = 2'd1;
                    push.w0    = '{cells: value, last: 1'b1};
                end
                fmenc_pkg::ACT_CRC_EMIT:
                begin
                    push.count = 2'd2;
                    push.w0    = '{cells: fmenc_pkg::encode_cells(dd_reg, prev_reg,
                                                                  crc_reg[15:8]),
                                   last: 1'b0};
                    push.w1    = '{cells: fmenc_pkg::encode_cells(dd_reg, prev_mid,
                                                                  crc_reg[7:0]),
                                   last: 1'b1};
                    // running a crc over its own value always leaves zero
                    crc_next   = 16'h0000;
                    prev_next  = dd_reg ? crc_reg[0] : prev_reg;
                end
                fmenc_pkg::ACT_CRC_RESET:
                begin
                    crc_next = fmenc_pkg::CRC_INIT;
                end
                fmenc_pkg::ACT_CRC_LOAD:
                begin
                    crc_next = value;
                end
                default:
                begin
                    crc_next = crc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dd_reg   <= 1'b1;
            prev_reg <= 1'b0;
            crc_reg  <= fmenc_pkg::CRC_INIT;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                dd_reg <= cfg_data;
            end
            prev_reg <= prev_next;
            crc_reg  <= crc_next;
        end
    end

    fmenc_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .head_valid (out_valid),
        .head_ready (out_ready),
        .head       (head)
    );

    assign cells = head.cells;
    assign last  = head.last;

    a_emit_clears_crc: assert property (@(posedge clk) disable iff (!rst_n)
        accept && action == fmenc_pkg::ACT_CRC_EMIT |=> crc_reg == 16'h0000)
        else $error("crc not zero after emit");

    a_load_crc: assert property (@(posedge clk) disable iff (!rst_n)
        accept && action == fmenc_pkg::ACT_CRC_LOAD |=> crc_reg == $past(value))
        else $error("crc load lost");

    a_reset_crc: assert property (@(posedge clk) disable iff (!rst_n)
        accept && action == fmenc_pkg::ACT_CRC_RESET |=> crc_reg == fmenc_pkg::CRC_INIT)
        else $error("crc reset lost");

    a_stall_has_output: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with empty queue");

    a_raw_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        accept && action == fmenc_pkg::ACT_RAW |=> $stable(crc_reg) && $stable(prev_reg))
        else $error("raw pattern changed state");

endmodule

`default_nettype wire

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the FM/MFM byte encoder with CRC-16.
// A directed table covers the corner actions and both clocking modes. Random
// sector-like records and noise follow, with random stalls on both sides and
// one long output hold-off. Every output word is checked against a local
// cell/crc predictor.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0]  ACT_SPARE_5   = 3'd5;
    localparam logic [2:0]  ACT_SPARE_6   = 3'd6;
    localparam logic [2:0]  ACT_SPARE_7   = 3'd7;
    localparam logic [15:0] MFM_SYNC      = 16'h4489;
    localparam logic [15:0] FM_INDEX_MARK = 16'hF57E;
    localparam int unsigned IDLE_PCT      = 21;
    localparam int unsigned STALL_LIMIT   = 1000;
    localparam int unsigned HOLD_CYCLES   = 80;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned PHASE_ITEMS   = 150;
    localparam int unsigned NUM_ROWS      = 26;

    typedef struct packed {
        logic        is_cfg;
        logic [2:0]  act;
        logic [15:0] val;
        logic        lit_ok;
        logic [15:0] lit;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  action;
    logic [15:0] value;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] cells;
    logic        last;

    // typed-in expectation that rides along with the driven transaction
    logic        drv_lit_ok;
    logic [15:0] drv_lit;

    // predictor state
    logic                mdl_mfm;
    logic                mdl_prev_bit;
    logic [15:0]         mdl_crc;
    fmenc_pkg::result_t  words_due [$];

    bit          no_idle;
    bit          hold_go;
    int unsigned errors;
    int unsigned items_sent;
    int unsigned words_checked;
    int unsigned emits_sent;
    int unsigned records_sent;
    int unsigned fm_items;

    row_t        dir_rows [NUM_ROWS];

    fm_mfm_byte_encoder_crc u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cells     (cells),
        .last      (last)
    );

    always #4 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        errors++;
        if (errors <= 200)
            $display("mismatch @%0t: %s got %h want %h", $realtime, what, got, want);
    endtask

    // clock/data cells for one byte, msb first, and fold the byte into the crc
    function automatic logic [15:0] encode_data_byte(input logic [7:0] b);
        logic [15:0] c;
        logic [15:0] r;
        logic        clk_cell;
        c = '0;
        for (int i = 7; i >= 0; i--)
        begin
            if (mdl_mfm)
            begin
                clk_cell     = !b[i] && !mdl_prev_bit;
                mdl_prev_bit = b[i];
            end
            else
                clk_cell = 1'b1;
            c = {c[13:0], clk_cell, b[i]};
        end
        r = mdl_crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
            r = r[15] ? ({r[14:0], 1'b0} ^ fmenc_pkg::CRC_POLY) : {r[14:0], 1'b0};
        mdl_crc = r;
        return c;
    endfunction

    task automatic predict_action(input logic [2:0] a, input logic [15:0] v,
                                  input logic lit_ok, input logic [15:0] lit);
        logic [15:0] held;
        logic [15:0] hi_cells;
        logic [15:0] lo_cells;
        case (a)
            fmenc_pkg::ACT_DATA:
            begin
                lo_cells = encode_data_byte(v[7:0]);
                words_due.push_back('{cells: lit_ok ? lit : lo_cells, last: 1'b1});
            end
            fmenc_pkg::ACT_RAW:
                words_due.push_back('{cells: lit_ok ? lit : v, last: 1'b1});
            fmenc_pkg::ACT_CRC_EMIT:
            begin
                held     = mdl_crc;
                hi_cells = encode_data_byte(held[15:8]);
                lo_cells = encode_data_byte(held[7:0]);
                words_due.push_back('{cells: hi_cells, last: 1'b0});
                words_due.push_back('{cells: lo_cells, last: 1'b1});
            end
            fmenc_pkg::ACT_CRC_RESET:
                mdl_crc = fmenc_pkg::CRC_INIT;
            fmenc_pkg::ACT_CRC_LOAD:
                mdl_crc = v;
            default:
                ;
        endcase
    endtask

    task automatic check_word(input logic [15:0] got_cells, input logic got_last);
        fmenc_pkg::result_t want;
        if (words_due.size() == 0)
        begin
            report_mismatch("word with nothing due, cells", got_cells, 16'h0);
            return;
        end
        want = words_due.pop_front();
        words_checked++;
        if (got_cells !== want.cells)
            report_mismatch("cells", got_cells, want.cells);
        if (got_last !== want.last)
            report_mismatch("last", {15'h0, got_last}, {15'h0, want.last});
    endtask

    // all predictor and checker sampling happens here at the rising edge, in one place
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                mdl_mfm = cfg_data;
            if (in_valid && in_ready)
                predict_action(action, value, drv_lit_ok, drv_lit);
            if (out_valid && out_ready)
                check_word(cells, last);
        end
    end

    // receiver: random stalls, a quiet stretch, and one long hold-off
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go)
            begin
                hold_go = 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                begin
                    out_ready <= 1'b0;
                    @(negedge clk);
                end
            end
            out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial
    begin : watchdog
        int unsigned dead_cycles;
        dead_cycles = 0;
        while (dead_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                dead_cycles = 0;
            else
                dead_cycles++;
        end
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("tb: errors");
        $finish;
    end

    task automatic push_item(input logic [2:0] a, input logic [15:0] v,
                             input logic lit_ok, input logic [15:0] lit);
        @(negedge clk);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        action     <= a;
        value      <= v;
        drv_lit_ok <= lit_ok;
        drv_lit    <= lit;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (a <= fmenc_pkg::ACT_CRC_LOAD)
            items_sent++;
        if (a == fmenc_pkg::ACT_CRC_EMIT)
            emits_sent++;
        if (!mdl_mfm)
            fm_items++;
    endtask

    // drain everything; crc reset/load make no word, so a settle wait follows
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (words_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic mfm);
        settle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= mfm;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // sync, address mark, payload, crc; sometimes cut short
    task automatic send_record(input int unsigned n_bytes, input bit broken);
        push_item(fmenc_pkg::ACT_CRC_RESET, 16'($urandom), 1'b0, 16'h0);
        if (mdl_mfm)
            repeat (3) push_item(fmenc_pkg::ACT_RAW, MFM_SYNC, 1'b0, 16'h0);
        else
            push_item(fmenc_pkg::ACT_RAW, FM_INDEX_MARK, 1'b0, 16'h0);
        push_item(fmenc_pkg::ACT_DATA, 16'($urandom_range(16'hFF, 16'hF8)), 1'b0, 16'h0);
        repeat (n_bytes) push_item(fmenc_pkg::ACT_DATA, 16'($urandom), 1'b0, 16'h0);
        if (!broken)
            push_item(fmenc_pkg::ACT_CRC_EMIT, 16'($urandom), 1'b0, 16'h0);
        records_sent++;
    endtask

    initial
    begin
        int unsigned target;
        int unsigned pick;
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = 1'b0;
        in_valid   = 1'b0;
        action     = fmenc_pkg::ACT_DATA;
        value      = 16'h0;
        drv_lit_ok = 1'b0;
        drv_lit    = 16'h0;
        mdl_mfm    = 1'b1;
        mdl_prev_bit = 1'b0;
        mdl_crc    = fmenc_pkg::CRC_INIT;
        no_idle    = 1'b0;
        hold_go    = 1'b0;

        dir_rows = '{
            '{1'b0, fmenc_pkg::ACT_DATA,      16'h0000, 1'b1, 16'hAAAA},  // all clocks set
            '{1'b0, fmenc_pkg::ACT_DATA,      16'hFFFF, 1'b1, 16'h5555},  // high byte ignored
            '{1'b0, fmenc_pkg::ACT_DATA,      16'h0000, 1'b1, 16'h2AAA},  // clock off after 1
            '{1'b0, fmenc_pkg::ACT_RAW,       MFM_SYNC, 1'b1, MFM_SYNC},
            '{1'b0, fmenc_pkg::ACT_RAW,       16'hFFFF, 1'b1, 16'hFFFF},
            '{1'b0, fmenc_pkg::ACT_RAW,       16'h0000, 1'b1, 16'h0000},
            '{1'b0, fmenc_pkg::ACT_CRC_RESET, 16'h1234, 1'b0, 16'h0000},
            '{1'b0, fmenc_pkg::ACT_CRC_EMIT,  16'h0000, 1'b0, 16'h0000},
            '{1'b0, fmenc_pkg::ACT_CRC_LOAD,  16'h0000, 1'b0, 16'h0000},
            '{1'b0, fmenc_pkg::ACT_CRC_EMIT,  16'hFFFF, 1'b0, 16'h0000},
            '{1'b0, fmenc_pkg::ACT_CRC_LOAD,  16'hFFFF, 1'b0, 16'h0000},
            '{1'b0, ACT_SPARE_5,              16'hFFFF, 1'b0, 16'h0000},
            '{1'b0, ACT_SPARE_6,              16'h0000, 1'b0, 16'h0000},
            '{1'b0, ACT_SPARE_7,              16'hA5A5, 1'b0, 16'h0000},
            '{1'b0, fmenc_pkg::ACT_CRC_EMIT,  16'h0000, 1'b0, 16'h0000},  // spares kept crc
            '{1'b0, fmenc_pkg::ACT_CRC_LOAD,  16'h8001, 1'b0, 16'h0000},
            '{1'b0, fmenc_pkg::ACT_DATA,      16'h0080, 1'b0, 16'h0000},
            '{1'b0, fmenc_pkg::ACT_DATA,      16'h0001, 1'b0, 16'h0000},
            '{1'b0, fmenc_pkg::ACT_CRC_EMIT,  16'h0000, 1'b0, 16'h0000},
            '{1'b1, fmenc_pkg::ACT_DATA,      16'h0000, 1'b0, 16'h0000},  // switch to fm
            '{1'b0, fmenc_pkg::ACT_DATA,      16'h0000, 1'b1, 16'hAAAA},
            '{1'b0, fmenc_pkg::ACT_DATA,      16'h00FF, 1'b1, 16'hFFFF},
            '{1'b0, fmenc_pkg::ACT_DATA,      16'h005A, 1'b0, 16'h0000},
            '{1'b0, fmenc_pkg::ACT_CRC_EMIT,  16'h0000, 1'b0, 16'h0000},
            '{1'b1, fmenc_pkg::ACT_DATA,      16'h0001, 1'b0, 16'h0000},  // back to mfm
            '{1'b0, fmenc_pkg::ACT_DATA,      16'h0000, 1'b0, 16'h0000}   // prev bit kept
        };

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int r = 0; r < NUM_ROWS; r++)
        begin
            if (dir_rows[r].is_cfg)
                write_mode(dir_rows[r].val[0]);
            else
                push_item(dir_rows[r].act, dir_rows[r].val, dir_rows[r].lit_ok,
                          dir_rows[r].lit);
        end

        for (int ph = 0; ph < 5; ph++)
        begin
            write_mode(ph % 2 == 1);
            no_idle = (ph == 1);
            if (ph == 3)
                hold_go = 1'b1;
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                pick = $urandom_range(99);
                if (pick < 80)
                    send_record($urandom_range(12), $urandom_range(9) == 0);
                else
                    push_item(3'($urandom_range(7)), 16'($urandom), 1'b0, 16'h0);
            end
        end
        no_idle = 1'b0;
        settle();

        if (words_due.size() != 0)
            report_mismatch("words never produced, count", 16'(words_due.size()), 16'h0);

        $display("run: %0d actions (%0d in fm), %0d records, %0d crc emits",
                 items_sent, fm_items, records_sent, emits_sent);
        $display("run: %0d output words checked, %0d mismatches", words_checked, errors);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
